[rtl/core/cslru_pkg.sv]
// Package for the connection slot LRU replacement core.
// Holds the opcode encoding and the input and result word types.
// No dependencies.
`timescale 1ns / 1ps

package cslru_pkg;

  localparam int unsigned SlotIdxW = 8;
  localparam int unsigned TimeInW  = 48;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_TOUCH   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [SlotIdxW-1:0]   slot_index;
    logic [TimeInW-1:0]    now_time;
    logic                  accept_ok;
  } in_word_t;

  typedef struct packed {
    logic [SlotIdxW-1:0]   chosen_slot;
    logic                  evicted;
    logic                  slot_live;
  } out_word_t;

endpackage

[rtl/core/cslru_age_mem.sv]
// Timestamp memory of the connection slot LRU core.
// One write port and one read port with registered read data; no dependencies.
`timescale 1ns / 1ps

module cslru_age_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 48,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/cslru_ctrl.sv]
// Sequencer of the connection slot LRU core: clearing pass, oldest-slot
// scan and read-modify-write of single slots. Uses cslru_pkg and drives
// the ports of cslru_age_mem.
`timescale 1ns / 1ps

module cslru_ctrl #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned TIME_BITS  = 48,
  localparam int unsigned IdxW      = $clog2(SLOT_COUNT)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cslru_pkg::in_word_t  in_word_i,
  input  logic [TIME_BITS-1:0] stamp_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output cslru_pkg::out_word_t res_word_o,
  output logic                 mem_rd_en_o,
  output logic [IdxW-1:0]      mem_rd_addr_o,
  input  logic [TIME_BITS-1:0] mem_rd_data_i,
  output logic                 mem_wr_en_o,
  output logic [IdxW-1:0]      mem_wr_addr_o,
  output logic [TIME_BITS-1:0] mem_wr_data_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_LOOK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                             state_q, state_d;
  logic [IdxW-1:0]                    addr_q, addr_d;
  cslru_pkg::opcode_e                 op_q, op_d;
  logic [cslru_pkg::SlotIdxW-1:0]     idx_q, idx_d;
  logic [TIME_BITS-1:0]               stamp_q, stamp_d;
  logic                               ok_q, ok_d;
  logic [IdxW-1:0]                    best_idx_q, best_idx_d;
  logic [TIME_BITS-1:0]               best_val_q, best_val_d;
  cslru_pkg::out_word_t               res_q, res_d;

  logic                               take;
  logic                               in_range;
  logic                               occupied;

  assign take     = (addr_q == '0) || (mem_rd_data_i < best_val_q);
  assign in_range = 32'(in_word_i.slot_index) < 32'(SLOT_COUNT);
  assign occupied = mem_rd_data_i != '0;

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    op_d          = op_q;
    idx_d         = idx_q;
    stamp_d       = stamp_q;
    ok_d          = ok_q;
    best_idx_d    = best_idx_q;
    best_val_d    = best_val_q;
    res_d         = res_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = '0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = '0;
    mem_wr_data_o = '0;
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = addr_q;
        addr_d        = addr_q + 1'b1;
        if (addr_q == LastIdx) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_word_i.opcode;
          idx_d   = in_word_i.slot_index;
          stamp_d = stamp_i;
          ok_d    = in_word_i.accept_ok;
          unique case (in_word_i.opcode)
            cslru_pkg::OP_ALLOC: begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = '0;
              addr_d        = '0;
              state_d       = ST_SCAN;
            end
            cslru_pkg::OP_TOUCH, cslru_pkg::OP_RELEASE: begin
              if (in_range) begin
                mem_rd_en_o   = 1'b1;
                mem_rd_addr_o = IdxW'(in_word_i.slot_index);
                state_d       = ST_LOOK;
              end else begin
                res_d   = '{chosen_slot: in_word_i.slot_index, evicted: 1'b0,
                            slot_live: 1'b0};
                state_d = ST_DONE;
              end
            end
            cslru_pkg::OP_NONE: begin
              res_d   = '{chosen_slot: in_word_i.slot_index, evicted: 1'b0,
                          slot_live: 1'b0};
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_idx_d = addr_q;
          best_val_d = mem_rd_data_i;
        end
        mem_rd_en_o   = addr_q != LastIdx;
        mem_rd_addr_o = addr_q + 1'b1;
        addr_d        = addr_q + 1'b1;
        if (best_val_d == '0 || addr_q == LastIdx) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = best_idx_d;
          mem_wr_data_o = ok_q ? stamp_q : '0;
          res_d         = '{chosen_slot: cslru_pkg::SlotIdxW'(best_idx_d),
                            evicted: best_val_d != '0, slot_live: ok_q};
          state_d       = ST_DONE;
        end
      end
      ST_LOOK: begin
        mem_wr_addr_o = IdxW'(idx_q);
        if (op_q == cslru_pkg::OP_TOUCH) begin
          mem_wr_en_o   = occupied;
          mem_wr_data_o = stamp_q;
          res_d         = '{chosen_slot: idx_q, evicted: 1'b0, slot_live: occupied};
        end else begin
          mem_wr_en_o   = 1'b1;
          mem_wr_data_o = '0;
          res_d         = '{chosen_slot: idx_q, evicted: occupied, slot_live: 1'b0};
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign res_word_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      op_q    <= cslru_pkg::OP_NONE;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    stamp_q    <= stamp_d;
    ok_q       <= ok_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    res_q      <= res_d;
  end

endmodule

[rtl/core/connection_slot_lru_replacement_core.sv]
// Top level of the connection slot LRU replacement core.
// Uses cslru_pkg and instantiates cslru_ctrl and cslru_age_mem.
// Forms the timestamp of each input word and holds the output register.
`timescale 1ns / 1ps

// The core keeps one activity timestamp per connection slot in a single
// synchronous memory, where zero marks a free slot. After reset it runs a
// clearing pass over every slot, during which no input word is taken.
// An allocate word scans the memory one slot per cycle and stops at the
// first free slot; when the table is full, the oldest slot is evicted.
// One word is worked on at a time; the next one is taken while a finished
// result still waits in the output register.

module connection_slot_lru_replacement_core #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cslru_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cslru_pkg::out_word_t out_word_o
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);

  logic [TIME_BITS-1:0] time_masked;
  logic [TIME_BITS-1:0] stamp;
  logic                 res_valid;
  logic                 res_ready;
  cslru_pkg::out_word_t res_word;
  logic                 mem_rd_en;
  logic [IdxW-1:0]      mem_rd_addr;
  logic [TIME_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [IdxW-1:0]      mem_wr_addr;
  logic [TIME_BITS-1:0] mem_wr_data;
  logic                 out_valid_q, out_valid_d;
  cslru_pkg::out_word_t out_word_q, out_word_d;

  assign time_masked = TIME_BITS'(in_word_i.now_time);
  assign stamp       = (time_masked == '0) ? TIME_BITS'(1) : time_masked;

  cslru_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .stamp_i      (stamp),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_word_o   (res_word),
    .mem_rd_en_o  (mem_rd_en),
    .mem_rd_addr_o(mem_rd_addr),
    .mem_rd_data_i(mem_rd_data),
    .mem_wr_en_o  (mem_wr_en),
    .mem_wr_addr_o(mem_wr_addr),
    .mem_wr_data_o(mem_wr_data)
  );

  cslru_age_mem #(
    .DEPTH (SLOT_COUNT),
    .DATA_W(TIME_BITS)
  ) u_age_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_word_d  = res_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
